>>> rtl/ibus_frame_receiver_unit_defines.svh
// Assertion macros for the iBus frame receiver
`ifndef IBUS_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define IBUS_FRAME_RECEIVER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define IBFR_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ibus frame receiver assertion failed");
`define IBFR_ASSERT_IMPLIES(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("ibus frame receiver assertion failed");
`define IBFR_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("ibus frame receiver assertion failed");
`else
`define IBFR_ASSERT(label, prop)
`define IBFR_ASSERT_IMPLIES(label, pre, post)
`define IBFR_ASSERT_NEXT(label, pre, post)
`endif

`endif

>>> rtl/ibusfr_pkg.sv
package ibusfr_pkg;

  localparam int NUM_CHANNELS  = 10;
  localparam int CH_IDX_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int RAM_ADDR_W    = CH_IDX_W + 1;
  localparam int RAM_DEPTH     = 2 ** RAM_ADDR_W;
  localparam int VALUE_W       = 16;
  localparam int POS_W         = 5;
  localparam int LEFT_W        = 6;
  localparam int WORD_W        = 4;

  localparam logic [WORD_W-1:0] NUM_CH_W = WORD_W'(NUM_CHANNELS);

  localparam logic [7:0]         SYNC_BYTE   = 8'h20;
  localparam logic [7:0]         TYPE_RESET  = 8'h40;
  localparam logic [VALUE_W-1:0] SUM_INIT    = 16'hFFFF;
  localparam logic [2:0]         IDLE_LIMIT_RESET = 3'd3;
  localparam logic [5:0]         FS_LIMIT_RESET   = 6'd32;
  localparam logic [2:0]         IDLE_MAX    = 3'd7;
  localparam logic [5:0]         FS_MAX      = 6'd63;
  localparam logic [LEFT_W-1:0]  FRAME_LEN   = 6'd32;

  localparam logic [POS_W-1:0] POS_SYNC     = 5'd0;
  localparam logic [POS_W-1:0] POS_TYPE     = 5'd1;
  localparam logic [POS_W-1:0] POS_FIRST_CH = 5'd2;
  localparam logic [POS_W-1:0] POS_CSUM_LO  = 5'd30;
  localparam logic [POS_W-1:0] POS_CSUM_HI  = 5'd31;

  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [1:0] ST_VALID     = 2'd0;
  localparam logic [1:0] ST_NO_FRAME  = 2'd1;
  localparam logic [1:0] ST_TIMED_OUT = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  localparam logic [1:0] CFG_EXPECTED_TYPE = 2'd0;
  localparam logic [1:0] CFG_IDLE_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_FS_LIMIT      = 2'd2;

endpackage

>>> rtl/ibusfr_ram.sv
module ibusfr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ibus_frame_receiver_unit.sv
// Results are registered: each appears in the cycle after its item is accepted.
// Throughput: one item per cycle while out_ready_i is 1; output drains as the next enters.
// Channel words sit in a two-bank RAM; a good frame flips the bank instead of copying.
// Reset clears frame position, tick counters, bank select and out_valid; checksum = FFFF.
// Channel RAM is not cleared; no frame-yet status keeps unwritten entries from being read.
`include "ibus_frame_receiver_unit_defines.svh"

module ibus_frame_receiver_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [1:0]                         cfg_index_i,
  input  logic [7:0]                         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         mode_i,
  input  logic [7:0]                         rx_byte_i,
  input  logic [3:0]                         channel_index_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ibusfr_pkg::VALUE_W-1:0]     read_value_o,
  output logic [1:0]                         read_status_o,
  output logic                               frame_accepted_o,
  output logic                               frame_rejected_o,
  output logic [ibusfr_pkg::LEFT_W-1:0]      bytes_left_o
);

  logic [7:0] type_q;
  logic [2:0] idle_limit_q;
  logic [5:0] fs_limit_q;

  logic [ibusfr_pkg::POS_W-1:0]   pos_q, pos_d;
  logic [ibusfr_pkg::VALUE_W-1:0] sum_q, sum_d;
  logic [7:0]                     low_q, low_d;
  logic [1:0]                     cond_q, cond_d;
  logic [2:0]                     idle_q, idle_d;
  logic [5:0]                     fs_q, fs_d;
  logic                           bank_q, bank_d;

  logic                                 out_valid_q, out_valid_d;
  logic [1:0]                           status_q, status_d;
  logic                                 acc_q, acc_d;
  logic                                 rej_q, rej_d;
  logic [ibusfr_pkg::LEFT_W-1:0]        left_q, left_d;
  logic                                 val_sel_q, val_sel_d;

  logic                                 in_fire;
  logic                                 restart;
  logic                                 commit;
  logic                                 frame_end;
  logic [3:0]                           next_idle;
  logic [6:0]                           next_fs;
  logic [ibusfr_pkg::POS_W-1:0]         pos_diff;
  logic [ibusfr_pkg::WORD_W-1:0]        word_k;
  logic [ibusfr_pkg::VALUE_W-1:0]       got;

  logic                                 ram_we;
  logic                                 ram_re;
  logic [ibusfr_pkg::RAM_ADDR_W-1:0]    ram_waddr;
  logic [ibusfr_pkg::RAM_ADDR_W-1:0]    ram_raddr;
  logic [ibusfr_pkg::VALUE_W-1:0]       ram_rdata;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  assign next_idle = {1'b0, idle_q} + 4'd1;
  assign next_fs   = {1'b0, fs_q} + 7'd1;
  assign pos_diff  = pos_q - ibusfr_pkg::POS_FIRST_CH;
  assign word_k    = pos_diff[ibusfr_pkg::POS_W-1:1];
  assign got       = {rx_byte_i, low_q};
  assign frame_end = in_fire && (mode_i == ibusfr_pkg::MODE_BYTE) &&
                     (pos_q == ibusfr_pkg::POS_CSUM_HI);

  assign ram_waddr = {~bank_q, word_k[ibusfr_pkg::CH_IDX_W-1:0]};
  assign ram_raddr = {bank_q, channel_index_i[ibusfr_pkg::CH_IDX_W-1:0]};

  always_comb begin
    pos_d     = pos_q;
    sum_d     = sum_q;
    low_d     = low_q;
    cond_d    = cond_q;
    idle_d    = idle_q;
    fs_d      = fs_q;
    bank_d    = bank_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    restart   = 1'b0;
    commit    = 1'b0;
    acc_d     = 1'b0;
    rej_d     = 1'b0;
    status_d  = ibusfr_pkg::ST_VALID;
    val_sel_d = 1'b0;
    if (in_fire) begin
      case (mode_i)
        ibusfr_pkg::MODE_BYTE: begin
          idle_d = '0;
          if (pos_q == ibusfr_pkg::POS_SYNC && rx_byte_i != ibusfr_pkg::SYNC_BYTE) begin
            pos_d = pos_q;
          end else if (pos_q == ibusfr_pkg::POS_TYPE && rx_byte_i != type_q) begin
            restart = 1'b1;
          end else begin
            if (pos_q < ibusfr_pkg::POS_CSUM_LO) begin
              sum_d = sum_q - {8'h00, rx_byte_i};
            end
            if (pos_q == ibusfr_pkg::POS_CSUM_HI) begin
              restart = 1'b1;
              if (got == sum_q) begin
                commit = 1'b1;
                acc_d  = 1'b1;
                cond_d = ibusfr_pkg::ST_VALID;
                fs_d   = '0;
                bank_d = ~bank_q;
              end else begin
                rej_d = 1'b1;
              end
            end else begin
              pos_d = pos_q + 5'd1;
              if (pos_q >= ibusfr_pkg::POS_FIRST_CH) begin
                if (!pos_q[0]) begin
                  low_d = rx_byte_i;
                end else if (pos_q < ibusfr_pkg::POS_CSUM_LO &&
                             word_k < ibusfr_pkg::NUM_CH_W) begin
                  ram_we = 1'b1;
                end
              end
            end
          end
        end
        ibusfr_pkg::MODE_TICK: begin
          if (next_idle > {1'b0, idle_limit_q}) begin
            restart = 1'b1;
          end
          idle_d = next_idle[3] ? ibusfr_pkg::IDLE_MAX : next_idle[2:0];
          if (next_fs > {1'b0, fs_limit_q}) begin
            cond_d = ibusfr_pkg::ST_TIMED_OUT;
          end
          fs_d = next_fs[6] ? ibusfr_pkg::FS_MAX : next_fs[5:0];
        end
        ibusfr_pkg::MODE_READ: begin
          if (channel_index_i >= ibusfr_pkg::NUM_CH_W) begin
            status_d = ibusfr_pkg::ST_BAD_INDEX;
          end else begin
            status_d = cond_q;
            if (cond_q == ibusfr_pkg::ST_VALID) begin
              ram_re    = 1'b1;
              val_sel_d = 1'b1;
            end
          end
        end
        default: begin
          pos_d = pos_q;
        end
      endcase
    end
    if (restart) begin
      pos_d = '0;
      sum_d = ibusfr_pkg::SUM_INIT;
      low_d = '0;
    end
    left_d = ibusfr_pkg::FRAME_LEN - {1'b0, pos_d};
  end

  always_comb begin
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q       <= ibusfr_pkg::TYPE_RESET;
      idle_limit_q <= ibusfr_pkg::IDLE_LIMIT_RESET;
      fs_limit_q   <= ibusfr_pkg::FS_LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ibusfr_pkg::CFG_EXPECTED_TYPE: type_q       <= cfg_data_i;
        ibusfr_pkg::CFG_IDLE_LIMIT:    idle_limit_q <= cfg_data_i[2:0];
        ibusfr_pkg::CFG_FS_LIMIT:      fs_limit_q   <= cfg_data_i[5:0];
        default: begin
          type_q <= type_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      sum_q       <= ibusfr_pkg::SUM_INIT;
      low_q       <= '0;
      cond_q      <= ibusfr_pkg::ST_NO_FRAME;
      idle_q      <= '0;
      fs_q        <= '0;
      bank_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      low_q       <= low_d;
      cond_q      <= cond_d;
      idle_q      <= idle_d;
      fs_q        <= fs_d;
      bank_q      <= bank_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q  <= status_d;
      acc_q     <= acc_d;
      rej_q     <= rej_d;
      left_q    <= left_d;
      val_sel_q <= val_sel_d;
    end
  end

  ibusfr_ram #(
    .WIDTH (ibusfr_pkg::VALUE_W),
    .DEPTH (ibusfr_pkg::RAM_DEPTH)
  ) u_chan_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (got),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign read_value_o     = val_sel_q ? ram_rdata : '0;
  assign read_status_o    = status_q;
  assign frame_accepted_o = acc_q;
  assign frame_rejected_o = rej_q;
  assign bytes_left_o     = left_q;

  // staging writes never land in the bank that reads see
  `IBFR_ASSERT(a_wr_staging_bank, !ram_we || (ram_waddr[ibusfr_pkg::RAM_ADDR_W-1] != bank_q))
  `IBFR_ASSERT_IMPLIES(a_flip_on_commit, bank_q != $past(bank_q), $past(commit))
  `IBFR_ASSERT_NEXT(a_frame_end_restart, frame_end, pos_q == '0 && sum_q == ibusfr_pkg::SUM_INIT)

endmodule
